@@ hdl/mgsp_pkg.sv @@
// Package for the motion-gated sine PWM block: widths, register codes,
// reset values and the cosine table, which is built at elaboration.
// No dependencies.
`default_nettype none

package mgsp_pkg;

	// Phase accumulators and cosine table geometry (table depth is a power of two)
	localparam int PHASE_W   = 16;
	localparam int COS_DEPTH = 256;
	localparam int COS_AW    = $clog2(COS_DEPTH);
	localparam int COS_W     = 17;

	// Configuration port
	localparam int CFG_DW = 16;
	localparam int CFG_AW = 3;

	typedef enum logic [CFG_AW-1:0] {
		REG_PWM_PERIOD   = 3'd0,
		REG_ALPHA_Q8     = 3'd1,
		REG_MOTION_THR   = 3'd2,
		REG_RGB_STEP     = 3'd3,
		REG_LED_STEP     = 3'd4,
		REG_BLINK_DIVIDE = 3'd5
	} cfg_reg_t;

	// Register reset values
	localparam logic [15:0] PWM_PERIOD_RST   = 16'd665;
	localparam logic [8:0]  ALPHA_Q8_RST     = 9'd154;
	localparam logic [8:0]  MOTION_THR_RST   = 9'd2;
	localparam logic [15:0] RGB_STEP_RST     = 16'd1043;
	localparam logic [15:0] LED_STEP_RST     = 16'd4172;
	localparam logic [7:0]  BLINK_DIVIDE_RST = 8'd10;

	// Unity weight of the gravity filter in Q8
	localparam logic [8:0] ALPHA_ONE = 9'd256;

	// Phase offsets: 120, 240 degrees and quarter turns
	localparam logic [PHASE_W-1:0] PH_THIRD =
		PHASE_W'(((64'd1 << PHASE_W) + 64'd1) / 64'd3);
	localparam logic [PHASE_W-1:0] PH_TWO_THIRDS =
		PHASE_W'(((64'd1 << (PHASE_W + 1)) + 64'd1) / 64'd3);
	localparam logic [PHASE_W-1:0] PH_QUARTER = PHASE_W'((64'd1 << PHASE_W) / 64'd4);

	// Divide by ten: floor(z * DIV10_MUL / 2^DIV10_SH) is exact for z below 2^22
	localparam int          DIV10_SH  = 25;
	localparam logic [21:0] DIV10_MUL = 22'd3355444;

	// Fixed-point constants of the table generator
	localparam logic [63:0] PI_HALF_Q30 = 64'd1686629713;
	localparam logic [63:0] ONE_Q30     = 64'd1 << 30;

	typedef logic signed [COS_W-1:0] cos_t;
	typedef cos_t cos_rom_t [COS_DEPTH];

	// Unsigned shift-and-subtract quotient for the table generator
	function automatic logic [63:0] udiv64(logic [63:0] num, logic [63:0] den);
		logic [63:0] quo;
		logic [64:0] rem;
		quo = '0;
		rem = '0;
		for (int b = 63; b >= 0; b--) begin
			rem = {rem[63:0], num[b]};
			if (rem >= {1'b0, den}) begin
				rem = rem - {1'b0, den};
				quo[b] = 1'b1;
			end
		end
		return quo;
	endfunction

	// Cosine in Q15 over one turn: Taylor series in Q30 per quadrant, then rounded
	function automatic cos_rom_t build_cos_rom();
		cos_rom_t rom;
		logic [63:0] f;
		logic [63:0] a;
		logic [63:0] term;
		logic [63:0] d;
		logic [63:0] v;
		logic signed [63:0] acc;
		logic signed [63:0] vs;
		logic [1:0] quad;
		logic odd;
		for (int i = 0; i < COS_DEPTH; i++) begin
			f = 64'(i) << (32 - COS_AW);
			quad = f[31:30];
			odd = quad[0];
			a = ({34'd0, f[29:0]} * PI_HALF_Q30) >> 30;
			term = odd ? a : ONE_Q30;
			acc = $signed(term);
			for (int k = 1; k <= 8; k++) begin
				d = odd ? 64'((2 * k) * (2 * k + 1)) : 64'((2 * k - 1) * (2 * k));
				term = udiv64((((term * a) >> 30) * a) >> 30, d);
				if ((k & 1) == 1) begin
					acc = acc - $signed(term);
				end else begin
					acc = acc + $signed(term);
				end
			end
			if (acc < 0) begin
				acc = 64'sd0;
			end
			if (acc > $signed(ONE_Q30)) begin
				acc = $signed(ONE_Q30);
			end
			v = (64'(acc) + 64'd16384) >> 15;
			vs = $signed(v);
			rom[i] = (quad == 2'd1 || quad == 2'd2) ? COS_W'(-vs) : COS_W'(vs);
		end
		return rom;
	endfunction

	localparam cos_rom_t COS_ROM = build_cos_rom();

endpackage

`default_nettype wire

@@ hdl/motion_gated_sine_pwm_top.sv @@
// Top level of the motion-gated sine PWM block: gravity filter, motion
// detect, phase accumulators, cosine lookup and duty scaling.
// Depends on mgsp_pkg.
//
// Usage:
//   Sample channel: accel_x/y/z with sample_valid; the block raises
//   sample_stall only when all three internal stages are full and the
//   result is held. Result channel: seven duties, blink_level and moved
//   with duty_valid; the receiver holds duty_stall to keep the result.
//   Pipeline: a transferred sample passes the input register, the
//   lookup/multiply stage and the output register. Throughput: one sample
//   per cycle while the receiver does not stall, set by one table read and
//   one multiplier per duty lane in the middle stage and one constant
//   multiply per LED lane in the output stage.
//   While the receiver stalls, the output holds and the earlier stages keep
//   filling; once they are full the sample side is stalled.
//   Configuration: cfg_we writes register cfg_index from cfg_data; write
//   only while no sample is in flight. blink_divide is used at the next
//   countdown reload.
//   Reset (arst_n low): registers go to their reset values, gravity
//   estimates and phases to zero, the blink countdown to ten, and the
//   pipeline empties.
`default_nettype none

module motion_gated_sine_pwm_top
	import mgsp_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,

	// Configuration write port
	input  wire logic                 cfg_we,
	input  wire logic [CFG_AW-1:0]    cfg_index,
	input  wire logic [CFG_DW-1:0]    cfg_data,

	// Sample channel
	input  wire logic                 sample_valid,
	output logic                      sample_stall,
	input  wire logic signed [7:0]    accel_x,
	input  wire logic signed [7:0]    accel_y,
	input  wire logic signed [7:0]    accel_z,

	// Result channel
	output logic                      duty_valid,
	input  wire logic                 duty_stall,
	output logic [15:0]               rgb_duty_0,
	output logic [15:0]               rgb_duty_120,
	output logic [15:0]               rgb_duty_240,
	output logic [15:0]               led_duty_0,
	output logic [15:0]               led_duty_90,
	output logic [15:0]               led_duty_180,
	output logic [15:0]               led_duty_270,
	output logic                      blink_level,
	output logic                      moved
);

	// Configuration registers
	logic [15:0] pwm_period_q;
	logic [8:0]  alpha_q8_q;
	logic [8:0]  motion_thr_q;
	logic [15:0] rgb_step_q;
	logic [15:0] led_step_q;
	logic [7:0]  blink_divide_q;

	// Block state
	logic signed [7:0]    gravity_q [3];
	logic [PHASE_W-1:0]   rgb_phase_q;
	logic [PHASE_W-1:0]   led_phase_q;
	logic [7:0]           blink_cnt_q;
	logic                 blink_q;

	// Pipeline registers
	logic                 v_s1;
	logic signed [7:0]    accel_s1 [3];
	logic                 v_s2;
	logic [15:0]          rgb_duty_s2 [3];
	logic [32:0]          led_prod_s2 [4];
	logic                 blink_s2;
	logic                 moved_s2;
	logic                 v_s3;
	logic [15:0]          rgb_duty_s3 [3];
	logic [15:0]          led_duty_s3 [4];
	logic                 blink_s3;
	logic                 moved_s3;

	// Stage enables
	logic en_s1;
	logic en_s2;
	logic en_s3;

	// Middle stage logic
	logic [8:0]           alpha_eff;
	logic [8:0]           alpha_inv;
	logic signed [17:0]   filt_sum [3];
	logic signed [7:0]    gravity_nxt [3];
	logic [7:0]           resid_mag [3];
	logic [8:0]           resid_total;
	logic                 moving;
	logic [7:0]           blink_cnt_dec;
	logic [7:0]           blink_cnt_nxt;
	logic                 blink_nxt;
	logic [PHASE_W-1:0]   rgb_lane_ph [3];
	logic [PHASE_W-1:0]   led_lane_ph [4];
	cos_t                 rgb_cos [3];
	cos_t                 led_cos [4];
	logic [31:0]          rgb_prod [3];
	logic [15:0]          rgb_duty_nxt [3];
	logic [16:0]          led_level [4];
	logic [32:0]          led_prod_nxt [4];

	// Output stage logic
	logic [36:0]          led_nine [4];
	logic [42:0]          led_div [4];
	logic [15:0]          led_duty_nxt [4];

	// Advance a stage when it is empty or the next one takes its transfer
	assign en_s3 = !v_s3 || !duty_stall;
	assign en_s2 = !v_s2 || en_s3;
	assign en_s1 = !v_s1 || en_s2;
	assign sample_stall = !en_s1;

	// Configuration writes; unknown indexes drop
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pwm_period_q   <= PWM_PERIOD_RST;
			alpha_q8_q     <= ALPHA_Q8_RST;
			motion_thr_q   <= MOTION_THR_RST;
			rgb_step_q     <= RGB_STEP_RST;
			led_step_q     <= LED_STEP_RST;
			blink_divide_q <= BLINK_DIVIDE_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_PWM_PERIOD:   pwm_period_q   <= cfg_data;
				REG_ALPHA_Q8:     alpha_q8_q     <= cfg_data[8:0];
				REG_MOTION_THR:   motion_thr_q   <= cfg_data[8:0];
				REG_RGB_STEP:     rgb_step_q     <= cfg_data;
				REG_LED_STEP:     led_step_q     <= cfg_data;
				REG_BLINK_DIVIDE: blink_divide_q <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// Gravity filter, residual magnitudes and motion decision
	always_comb begin
		alpha_eff = (alpha_q8_q > ALPHA_ONE) ? ALPHA_ONE : alpha_q8_q;
		alpha_inv = ALPHA_ONE - alpha_eff;
		for (int i = 0; i < 3; i++) begin
			filt_sum[i] = 18'(gravity_q[i]) * 18'($signed({1'b0, alpha_eff}))
				+ 18'(accel_s1[i]) * 18'($signed({1'b0, alpha_inv}));
			// truncate toward zero: round negative values with a fraction up
			gravity_nxt[i] = 8'(filt_sum[i] >>> 8)
				+ 8'((filt_sum[i] < 0 && filt_sum[i][7:0] != 8'd0) ? 1 : 0);
			resid_mag[i] = 8'(accel_s1[i] - gravity_nxt[i]);
			if (resid_mag[i][7]) begin
				resid_mag[i] = 8'(-resid_mag[i]);
			end
		end
		resid_total = 9'(resid_mag[0]) + 9'(resid_mag[1]) + 9'(resid_mag[2]);
		moving = resid_total > motion_thr_q;
	end

	// Blink countdown; a reload of zero wraps through the full count
	always_comb begin
		blink_cnt_dec = blink_cnt_q - 8'd1;
		blink_cnt_nxt = blink_cnt_dec;
		blink_nxt = blink_q;
		if (blink_cnt_dec == 8'd0) begin
			blink_cnt_nxt = blink_divide_q;
			blink_nxt = !blink_q;
		end
	end

	// Cosine lookup and period scaling from the phases held before this sample
	always_comb begin
		rgb_lane_ph[0] = rgb_phase_q;
		rgb_lane_ph[1] = rgb_phase_q + PH_THIRD;
		rgb_lane_ph[2] = rgb_phase_q + PH_TWO_THIRDS;
		for (int i = 0; i < 4; i++) begin
			led_lane_ph[i] = led_phase_q + PHASE_W'(PH_QUARTER * PHASE_W'(i));
		end
		for (int i = 0; i < 3; i++) begin
			rgb_cos[i] = COS_ROM[rgb_lane_ph[i][PHASE_W-1 -: COS_AW]];
			rgb_prod[i] = 32'(pwm_period_q) * 32'(rgb_cos[i][15:0]);
			rgb_duty_nxt[i] = (rgb_cos[i] > 0) ? rgb_prod[i][30:15] : 16'd0;
		end
		for (int i = 0; i < 4; i++) begin
			led_cos[i] = COS_ROM[led_lane_ph[i][PHASE_W-1 -: COS_AW]];
			led_level[i] = 17'(led_cos[i] + cos_t'(32768));
			led_prod_nxt[i] = 33'(pwm_period_q) * 33'(led_level[i]);
		end
	end

	// Input register: capture the sample on transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en_s1) begin
			v_s1 <= sample_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1 && sample_valid) begin
			accel_s1[0] <= accel_x;
			accel_s1[1] <= accel_y;
			accel_s1[2] <= accel_z;
		end
	end

	// Middle stage: update block state once per sample as it leaves the input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2        <= 1'b0;
			for (int i = 0; i < 3; i++) begin
				gravity_q[i] <= 8'sd0;
			end
			rgb_phase_q <= '0;
			led_phase_q <= '0;
			blink_cnt_q <= BLINK_DIVIDE_RST;
			blink_q     <= 1'b0;
		end else if (en_s2) begin
			v_s2 <= v_s1;
			if (v_s1) begin
				for (int i = 0; i < 3; i++) begin
					gravity_q[i] <= gravity_nxt[i];
				end
				blink_cnt_q <= blink_cnt_nxt;
				blink_q     <= blink_nxt;
				if (moving) begin
					rgb_phase_q <= rgb_phase_q + rgb_step_q;
					led_phase_q <= led_phase_q + led_step_q;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en_s2 && v_s1) begin
			rgb_duty_s2 <= rgb_duty_nxt;
			led_prod_s2 <= led_prod_nxt;
			blink_s2    <= blink_nxt;
			moved_s2    <= moving;
		end
	end

	// Output stage: LED duty = floor(9 * period * level / 2^16 / 10)
	always_comb begin
		for (int i = 0; i < 4; i++) begin
			led_nine[i] = (37'(led_prod_s2[i]) << 3) + 37'(led_prod_s2[i]);
			led_div[i] = 43'(led_nine[i][36:16]) * 43'(DIV10_MUL);
			led_duty_nxt[i] = led_div[i][DIV10_SH +: 16];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en_s3) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s3 && v_s2) begin
			rgb_duty_s3 <= rgb_duty_s2;
			led_duty_s3 <= led_duty_nxt;
			blink_s3    <= blink_s2;
			moved_s3    <= moved_s2;
		end
	end

	// Drive the result channel from the output register
	assign duty_valid   = v_s3;
	assign rgb_duty_0   = rgb_duty_s3[0];
	assign rgb_duty_120 = rgb_duty_s3[1];
	assign rgb_duty_240 = rgb_duty_s3[2];
	assign led_duty_0   = led_duty_s3[0];
	assign led_duty_90  = led_duty_s3[1];
	assign led_duty_180 = led_duty_s3[2];
	assign led_duty_270 = led_duty_s3[3];
	assign blink_level  = blink_s3;
	assign moved        = moved_s3;

	// Phases move only when a sample leaves the input register
	a_phase_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!(en_s2 && v_s1) |=> $stable(rgb_phase_q) && $stable(led_phase_q))
		else $error("phase changed without a sample transfer");

	// Blink state moves only when a sample leaves the input register
	a_blink_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!(en_s2 && v_s1) |=> $stable(blink_q) && $stable(blink_cnt_q))
		else $error("blink state changed without a sample transfer");

	// Three cosines a third of a turn apart are never all positive
	a_rgb_not_all_on: assert property (@(posedge clk) disable iff (!arst_n)
		duty_valid |-> !(rgb_duty_0 != 16'd0 && rgb_duty_120 != 16'd0
			&& rgb_duty_240 != 16'd0))
		else $error("all three rgb duties nonzero");

endmodule

`default_nettype wire

@@ tb/motion_gated_sine_pwm_top_test.sv @@
// Self-checking bench for motion_gated_sine_pwm_top: drives accelerometer samples
// under random gaps and result stalls, predicts every duty set and compares it.
// Depends on mgsp_pkg and motion_gated_sine_pwm_top.

module motion_gated_sine_pwm_top_test;
	timeunit 1ns;
	timeprecision 1ps;

	import mgsp_pkg::*;

	localparam int TURN          = 1 << PHASE_W;
	localparam int OFF_90        = TURN / 4;
	localparam int OFF_120       = (TURN + 1) / 3;
	localparam int OFF_240       = (2 * TURN + 1) / 3;
	localparam int SETTLE_CYCLES = 4;
	localparam int IDLE_LIMIT    = 2000;
	localparam int LONG_HOLD     = 60;

	// Indexes with no register behind them
	localparam logic [CFG_AW-1:0] REG_SPARE_6 = 3'd6;
	localparam logic [CFG_AW-1:0] REG_SPARE_7 = 3'd7;

	// Opening samples: zero, both rails, mixed rails, small and odd values
	localparam logic [23:0] OPENING_SAMPLES [10] = '{
		24'h000000, 24'h7F7F7F, 24'h808080, 24'h7F8000, 24'h807FFF,
		24'hFFFFFF, 24'h01FF00, 24'h000000, 24'h55AA2A, 24'hD51595
	};

	typedef enum int {
		STALL_NEVER,
		STALL_RANDOM,
		STALL_RUNS,
		STALL_HEAVY
	} stall_mode_t;

	typedef struct packed {
		logic [15:0] rgb_0;
		logic [15:0] rgb_120;
		logic [15:0] rgb_240;
		logic [15:0] led_0;
		logic [15:0] led_90;
		logic [15:0] led_180;
		logic [15:0] led_270;
		logic        blink;
		logic        moved;
	} duty_set_t;

	// Duty predictor and the queue of duty sets still owed by the block
	class duty_ledger;
		int period;
		int alpha;
		int threshold;
		int rgb_step;
		int led_step;
		int blink_div;
		int gravity [3];
		int rgb_phase;
		int led_phase;
		int countdown;
		bit blink;
		int cos_q15 [COS_DEPTH];
		duty_set_t expected_duties [$];
		int errors;

		// Build the Q15 cosine table and load the reset state
		function new();
			bit [63:0] f;
			bit [63:0] ang;
			bit [63:0] term;
			bit [63:0] div;
			bit [1:0] quad;
			longint acc;
			longint mag;
			for (int i = 0; i < COS_DEPTH; i++) begin
				f = (64'(i) << 32) / COS_DEPTH;
				quad = f[31:30];
				ang = ((f & 64'h3FFF_FFFF) * 64'd1686629713) >> 30;
				term = quad[0] ? ang : (64'd1 << 30);
				acc = longint'(term);
				for (int k = 1; k <= 8; k++) begin
					div = quad[0] ? 64'((2 * k) * (2 * k + 1)) : 64'((2 * k - 1) * (2 * k));
					term = ((((term * ang) >> 30) * ang) >> 30) / div;
					if (k % 2 == 1) begin
						acc -= longint'(term);
					end else begin
						acc += longint'(term);
					end
				end
				if (acc < 0) begin
					acc = 0;
				end
				if (acc > (longint'(1) << 30)) begin
					acc = longint'(1) << 30;
				end
				mag = (acc + 16384) >> 15;
				cos_q15[i] = (quad == 2'd1 || quad == 2'd2) ? -int'(mag) : int'(mag);
			end
			period = 665;
			alpha = 154;
			threshold = 2;
			rgb_step = 1043;
			led_step = 4172;
			blink_div = 10;
			gravity = '{0, 0, 0};
			rgb_phase = 0;
			led_phase = 0;
			countdown = 10;
			blink = 1'b0;
			errors = 0;
		endfunction

		function void apply_register(logic [CFG_AW-1:0] idx, logic [CFG_DW-1:0] data);
			case (idx)
				REG_PWM_PERIOD:   period = data;
				REG_ALPHA_Q8:     alpha = data[8:0];
				REG_MOTION_THR:   threshold = data[8:0];
				REG_RGB_STEP:     rgb_step = data;
				REG_LED_STEP:     led_step = data;
				REG_BLINK_DIVIDE: blink_div = data[7:0];
				default: ;
			endcase
		endfunction

		function int cos_at(int phase, int offset);
			return cos_q15[((longint'(phase + offset) & (TURN - 1)) * COS_DEPTH) >> PHASE_W];
		endfunction

		function logic [15:0] rgb_duty(int c);
			if (c <= 0) begin
				return 16'd0;
			end
			return 16'((longint'(period) * c) >> 15);
		endfunction

		function logic [15:0] led_duty(int c);
			return 16'((longint'(period) * (32768 + c) * 9) / 655360);
		endfunction

		// Filter gravity, detect motion, form duties from the held phases, then advance
		function void note_sample(logic signed [7:0] ax, logic signed [7:0] ay,
				logic signed [7:0] az);
			duty_set_t want;
			int weight;
			int a;
			int r;
			int sum;
			int axis [3];
			axis = '{ax, ay, az};
			weight = (alpha > 256) ? 256 : alpha;
			sum = 0;
			for (int i = 0; i < 3; i++) begin
				a = axis[i];
				gravity[i] = (gravity[i] * weight + a * (256 - weight)) / 256;
				r = ((a - gravity[i] + 128) & 255) - 128;
				sum += (r < 0) ? -r : r;
			end
			want.moved = (sum > threshold);
			want.rgb_0 = rgb_duty(cos_at(rgb_phase, 0));
			want.rgb_120 = rgb_duty(cos_at(rgb_phase, OFF_120));
			want.rgb_240 = rgb_duty(cos_at(rgb_phase, OFF_240));
			want.led_0 = led_duty(cos_at(led_phase, 0));
			want.led_90 = led_duty(cos_at(led_phase, OFF_90));
			want.led_180 = led_duty(cos_at(led_phase, 2 * OFF_90));
			want.led_270 = led_duty(cos_at(led_phase, 3 * OFF_90));
			countdown = (countdown - 1) & 255;
			if (countdown == 0) begin
				blink = ~blink;
				countdown = blink_div;
			end
			want.blink = blink;
			if (want.moved) begin
				rgb_phase = (rgb_phase + rgb_step) & (TURN - 1);
				led_phase = (led_phase + led_step) & (TURN - 1);
			end
			expected_duties.push_back(want);
		endfunction

		task report(string msg);
			if (errors < 50) begin
				$display("%0t ns mismatch: %s", $time, msg);
			end
			errors++;
		endtask

		task compare_field(string field, int got, int want);
			if (got != want) begin
				report($sformatf("%s got %0d, want %0d", field, got, want));
			end
		endtask

		// Match one duty transfer against the oldest owed set
		task check_duties(duty_set_t got);
			duty_set_t want;
			if (expected_duties.size() == 0) begin
				report("duty transfer with no sample pending");
				return;
			end
			want = expected_duties.pop_front();
			compare_field("rgb_duty_0", got.rgb_0, want.rgb_0);
			compare_field("rgb_duty_120", got.rgb_120, want.rgb_120);
			compare_field("rgb_duty_240", got.rgb_240, want.rgb_240);
			compare_field("led_duty_0", got.led_0, want.led_0);
			compare_field("led_duty_90", got.led_90, want.led_90);
			compare_field("led_duty_180", got.led_180, want.led_180);
			compare_field("led_duty_270", got.led_270, want.led_270);
			compare_field("blink_level", got.blink, want.blink);
			compare_field("moved", got.moved, want.moved);
		endtask
	endclass

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_AW-1:0] cfg_index;
	logic [CFG_DW-1:0] cfg_data;
	logic sample_valid;
	logic sample_stall;
	logic signed [7:0] accel_x;
	logic signed [7:0] accel_y;
	logic signed [7:0] accel_z;
	logic duty_valid;
	logic duty_stall;
	logic [15:0] rgb_duty_0;
	logic [15:0] rgb_duty_120;
	logic [15:0] rgb_duty_240;
	logic [15:0] led_duty_0;
	logic [15:0] led_duty_90;
	logic [15:0] led_duty_180;
	logic [15:0] led_duty_270;
	logic blink_level;
	logic moved;

	duty_set_t observed;
	duty_ledger ledger;
	int idle_cycles = 0;
	int hold_requests = 0;
	stall_mode_t stall_mode = STALL_RANDOM;
	int base_x;
	int base_y;
	int base_z;

	motion_gated_sine_pwm_top i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.accel_x      (accel_x),
		.accel_y      (accel_y),
		.accel_z      (accel_z),
		.duty_valid   (duty_valid),
		.duty_stall   (duty_stall),
		.rgb_duty_0   (rgb_duty_0),
		.rgb_duty_120 (rgb_duty_120),
		.rgb_duty_240 (rgb_duty_240),
		.led_duty_0   (led_duty_0),
		.led_duty_90  (led_duty_90),
		.led_duty_180 (led_duty_180),
		.led_duty_270 (led_duty_270),
		.blink_level  (blink_level),
		.moved        (moved)
	);

	assign observed = {rgb_duty_0, rgb_duty_120, rgb_duty_240, led_duty_0, led_duty_90,
		led_duty_180, led_duty_270, blink_level, moved};

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Watch both channels at each edge; results are checked before the new sample is noted
	always @(posedge clk) begin
		if (arst_n) begin
			if (duty_valid && !duty_stall) begin
				ledger.check_duties(observed);
			end
			if (sample_valid && !sample_stall) begin
				ledger.note_sample(accel_x, accel_y, accel_z);
			end
			if ((duty_valid && !duty_stall) || (sample_valid && !sample_stall)) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
			end
		end
	end

	// Give up when no transfer has happened for too long
	initial begin
		wait (idle_cycles >= IDLE_LIMIT);
		$display("[FAIL] regression broken");
		$finish;
	end

	// Result stalls: a long hold on request, otherwise the current pattern
	initial begin
		int seen_holds;
		int run_left;
		seen_holds = 0;
		run_left = 0;
		duty_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_requests != seen_holds) begin
				seen_holds = hold_requests;
				duty_stall <= 1'b1;
				repeat (LONG_HOLD) @(posedge clk);
				duty_stall <= 1'b0;
			end else begin
				case (stall_mode)
					STALL_NEVER:  duty_stall <= 1'b0;
					STALL_RANDOM: duty_stall <= ($urandom_range(0, 3) == 0);
					STALL_HEAVY:  duty_stall <= ($urandom_range(0, 3) != 0);
					default: begin
						if (run_left == 0) begin
							run_left = $urandom_range(1, 8);
							duty_stall <= ~duty_stall;
						end else begin
							run_left--;
						end
					end
				endcase
			end
		end
	end

	// Offer one sample and hold it until the transfer
	task automatic send_sample(input logic signed [7:0] x, input logic signed [7:0] y,
			input logic signed [7:0] z);
		sample_valid <= 1'b1;
		accel_x <= x;
		accel_y <= y;
		accel_z <= z;
		@(posedge clk);
		while (sample_stall) @(posedge clk);
	endtask

	function automatic logic signed [7:0] jitter(int center, int spread);
		int v;
		v = center + int'($urandom_range(0, 2 * spread)) - spread;
		if (v > 127) begin
			v = 127;
		end
		if (v < -128) begin
			v = -128;
		end
		return 8'(v);
	endfunction

	// Random samples in bursts: near a resting vector, fully random, or shaken
	task automatic send_batch(input int count, input bit with_gaps);
		int burst;
		int gap;
		int kind;
		burst = 0;
		for (int n = 0; n < count; n++) begin
			if (with_gaps && burst == 0) begin
				burst = $urandom_range(1, 16);
				gap = $urandom_range(0, 6);
				if (gap != 0) begin
					sample_valid <= 1'b0;
					repeat (gap) @(posedge clk);
				end
			end
			if (n % 50 == 0) begin
				base_x = int'($urandom_range(0, 255)) - 128;
				base_y = int'($urandom_range(0, 255)) - 128;
				base_z = int'($urandom_range(0, 255)) - 128;
			end
			kind = $urandom_range(0, 9);
			if (kind < 4) begin
				send_sample(jitter(base_x, 2), jitter(base_y, 2), jitter(base_z, 2));
			end else if (kind < 7) begin
				send_sample(8'($urandom), 8'($urandom), 8'($urandom));
			end else begin
				send_sample(jitter(base_x, 40), jitter(base_y, 40), jitter(base_z, 40));
			end
			burst--;
		end
	endtask

	// Drop valid, wait until every owed duty set has arrived, then let the pipe empty
	task automatic settle();
		sample_valid <= 1'b0;
		do @(posedge clk); while (ledger.expected_duties.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// One register write; the caller lowers the write enable after the last one
	task automatic write_reg(input logic [CFG_AW-1:0] idx, input logic [CFG_DW-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		ledger.apply_register(idx, data);
	endtask

	// Write every register, plus a write to an index with no register behind it
	task automatic set_regs(input logic [15:0] period, input logic [15:0] alpha,
			input logic [15:0] thr, input logic [15:0] rgb_step, input logic [15:0] led_step,
			input logic [15:0] blink_div);
		write_reg(REG_PWM_PERIOD, period);
		write_reg(REG_ALPHA_Q8, alpha);
		write_reg(REG_MOTION_THR, thr);
		write_reg(REG_RGB_STEP, rgb_step);
		write_reg(REG_LED_STEP, led_step);
		write_reg(REG_BLINK_DIVIDE, blink_div);
		write_reg($urandom_range(0, 1) ? REG_SPARE_6 : REG_SPARE_7, 16'($urandom));
		cfg_we <= 1'b0;
	endtask

	// Random settings with junk in the unused upper data bits
	task automatic random_regs();
		logic [15:0] period;
		logic [15:0] alpha;
		logic [15:0] thr;
		logic [15:0] blink_div;
		if ($urandom_range(0, 3) == 0) begin
			period = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
		end else begin
			period = 16'($urandom);
		end
		if ($urandom_range(0, 4) == 0) begin
			alpha = 16'($urandom);
		end else begin
			alpha = (16'($urandom) & 16'hFE00) | 16'($urandom_range(0, 256));
		end
		if ($urandom_range(0, 3) == 0) begin
			thr = 16'($urandom);
		end else begin
			thr = (16'($urandom) & 16'hFE00) | 16'($urandom_range(0, 40));
		end
		blink_div = 16'($urandom) & 16'hFF00;
		if ($urandom_range(0, 7) != 0) begin
			blink_div = blink_div | 16'($urandom_range(1, 255));
		end
		set_regs(period, alpha, thr, 16'($urandom), 16'($urandom), blink_div);
	endtask

	initial begin
		ledger = new();
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= REG_PWM_PERIOD;
		cfg_data <= '0;
		sample_valid <= 1'b0;
		accel_x <= '0;
		accel_y <= '0;
		accel_z <= '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// Reset settings: opening samples, then random traffic
		for (int i = 0; i < 10; i++) begin
			send_sample(OPENING_SAMPLES[i][23:16], OPENING_SAMPLES[i][15:8],
				OPENING_SAMPLES[i][7:0]);
		end
		send_batch(60, 1'b1);
		settle();

		// Estimate follows the input at once, full-scale period, RGB phase wraps on every step;
		// the last sample parks the estimates at -128, 127 and -1
		set_regs(16'hFFFF, 16'h0000, 16'h0000, 16'hFFFF, 16'h0001, 16'h0001);
		send_batch(60, 1'b1);
		send_sample(8'sh80, 8'sh7F, 8'shFF);
		settle();

		// Alpha above unity freezes the estimates; residuals wrap at 128;
		// blink divide of zero makes the level toggle every 256 samples
		stall_mode <= STALL_RUNS;
		set_regs(16'd40000, 16'hFFFF, 16'd383, 16'd777, 16'hFFFF, 16'hFF00);
		send_sample(8'sh00, 8'shFF, 8'sh7F);
		send_sample(8'sh7F, 8'sh80, 8'sh80);
		send_batch(280, 1'b1);
		settle();

		// Zero period, alpha 300 behind junk bits, highest threshold, blink divide of 255
		stall_mode <= STALL_HEAVY;
		set_regs(16'h0000, 16'hFF2C, 16'hFFFF, 16'($urandom), 16'($urandom), 16'hFFFF);
		send_batch(40, 1'b1);
		settle();

		// Random settings under each stall pattern; one long hold-off fills the pipe
		for (int j = 0; j < 6; j++) begin
			random_regs();
			case (j)
				2:       stall_mode <= STALL_NEVER;
				3:       stall_mode <= STALL_RUNS;
				4:       stall_mode <= STALL_HEAVY;
				default: stall_mode <= STALL_RANDOM;
			endcase
			if (j == 1) begin
				hold_requests <= hold_requests + 1;
			end
			send_batch(100, j != 1 && j != 2);
			settle();
		end

		@(negedge clk);
		if (ledger.errors == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
